// ===== rtl/crc32w_pkg.sv =====
// crc32w_pkg: constants shared by the msb-first crc-32 word engine
// no dependencies; imported by crc32w_fold, crc32_msb_first_word_engine and testbench
package crc32w_pkg;

  localparam int unsigned CrcWidth     = 32;
  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned CountWidth   = 3;
  localparam int unsigned IdxWidth     = 2;
  localparam int unsigned CrcByteShift = 24;

  localparam logic [CrcWidth-1:0]   CrcAllOnes   = 32'hFFFF_FFFF;
  localparam logic [CrcWidth-1:0]   CrcTopBit    = 32'h8000_0000;
  localparam logic [CrcWidth-1:0]   CrcPolyReset = 32'h04C1_1DB7;
  localparam logic [CountWidth-1:0] ByteCountMax = 3'd4;

  typedef logic [CrcWidth-1:0]  crc_t;
  typedef logic [ByteWidth-1:0] byte_t;

endpackage

// ===== rtl/crc32_msb_first_word_engine.sv =====
// crc32_msb_first_word_engine: non-reflected crc-32 over words of 0 to 4 bytes
// rate: one byte folded per cycle, but the final byte of a last item waits while
//   the output is stalled; the next item is taken in the cycle its predecessor finishes
// reset: remainder reads as zero, polynomial 0x04C11DB7, no item or result held
// depends on crc32w_pkg and crc32w_fold
module crc32_msb_first_word_engine import crc32w_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CrcWidth-1:0]   cfg_wdata_i,
  // input items
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CrcWidth-1:0]   data_word_i,
  input  logic [CountWidth-1:0] byte_count_i,
  input  logic                  first_word_i,
  input  logic                  last_word_i,
  input  logic [CrcWidth-1:0]   prior_crc_i,
  // result items
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CrcWidth-1:0]   crc_result_o
);

  // polynomial register
  crc_t poly_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= CrcPolyReset;
    end else if (cfg_we_i) begin
      poly_q <= cfg_wdata_i;
    end
  end

  // work stage registers
  logic                  a_vld_q;
  logic                  a_start_q;
  logic [IdxWidth-1:0]   a_idx_q;
  logic [CountWidth-1:0] a_cnt_q;
  logic                  a_first_q;
  logic                  a_last_q;
  crc_t                  a_word_q;
  crc_t                  a_prior_q;
  crc_t                  a_rem_q;

  // remainder memory, one entry, registered read
  crc_t rem_mem [1];
  crc_t rd_q;
  logic rem_vld_q;
  logic fwd_q;
  crc_t fwd_data_q;
  logic wr_en;
  crc_t wr_data;
  crc_t mem_rd;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rem_mem[0] <= wr_data;
    end
    rd_q       <= rem_mem[0];
    fwd_data_q <= wr_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_vld_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      fwd_q <= wr_en;
      if (wr_en) begin
        rem_vld_q <= 1'b1;
      end
    end
  end

  // stored remainder, forwarding a write made in the previous cycle
  always_comb begin
    if (fwd_q) begin
      mem_rd = fwd_data_q;
    end else if (rem_vld_q) begin
      mem_rd = rd_q;
    end else begin
      mem_rd = '0;
    end
  end

  // remainder entering this cycle's fold
  crc_t cur_rem;

  always_comb begin
    if (!a_start_q) begin
      cur_rem = a_rem_q;
    end else if (a_first_q) begin
      cur_rem = a_prior_q ^ CrcAllOnes;
    end else begin
      cur_rem = mem_rd;
    end
  end

  // byte selection, oldest byte at the top
  byte_t cur_byte;

  always_comb begin
    case (a_idx_q)
      2'd0:    cur_byte = a_word_q[31:24];
      2'd1:    cur_byte = a_word_q[23:16];
      2'd2:    cur_byte = a_word_q[15:8];
      default: cur_byte = a_word_q[7:0];
    endcase
  end

  crc_t fold_rem;

  crc32w_fold u_fold (
    .rem_i  (cur_rem),
    .byte_i (cur_byte),
    .poly_i (poly_q),
    .rem_o  (fold_rem)
  );

  // completion and commit
  logic no_bytes;
  logic done;
  logic out_free;
  logic commit;
  logic in_accept;
  crc_t end_rem;

  assign no_bytes  = (a_cnt_q == '0);
  assign done      = a_vld_q && (no_bytes || ({1'b0, a_idx_q} == a_cnt_q - 3'd1));
  assign out_free  = !out_valid_o || !out_stall_i;
  assign commit    = done && (!a_last_q || out_free);
  assign end_rem   = no_bytes ? cur_rem : fold_rem;
  assign wr_en     = commit;
  assign wr_data   = end_rem;
  assign in_stall_o = a_vld_q && !commit;
  assign in_accept = in_valid_i && !in_stall_o;

  // work stage update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      a_start_q <= 1'b0;
      a_idx_q   <= '0;
    end else if (in_accept) begin
      a_vld_q   <= 1'b1;
      a_start_q <= 1'b1;
      a_idx_q   <= '0;
    end else if (commit) begin
      a_vld_q   <= 1'b0;
      a_start_q <= 1'b0;
    end else if (a_vld_q && !done) begin
      a_start_q <= 1'b0;
      a_idx_q   <= a_idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_word_q  <= data_word_i;
      a_cnt_q   <= (byte_count_i > ByteCountMax) ? ByteCountMax : byte_count_i;
      a_first_q <= first_word_i;
      a_last_q  <= last_word_i;
      a_prior_q <= prior_crc_i;
    end
    if (a_vld_q && !done) begin
      a_rem_q <= fold_rem;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (commit && a_last_q) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && a_last_q) begin
      crc_result_o <= end_rem ^ CrcAllOnes;
    end
  end

  // checks
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_vld_q && !no_bytes) |-> ({1'b0, a_idx_q} < a_cnt_q))
    else $error("byte index beyond byte count");

  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_vld_q |-> (a_cnt_q <= ByteCountMax))
    else $error("stored byte count above four");

  a_out_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(commit && a_last_q))
    else $error("result appeared without a finished last item");

  a_fwd_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> rem_vld_q)
    else $error("forwarded remainder without a stored entry");

endmodule

// ===== rtl/crc32w_fold.sv =====
// crc32w_fold: folds one message byte into a 32-bit remainder, msb first
// depends on crc32w_pkg
module crc32w_fold import crc32w_pkg::*; (
  input  crc_t  rem_i,
  input  byte_t byte_i,
  input  crc_t  poly_i,
  output crc_t  rem_o
);

  // eight shift-and-conditional-xor steps of modulo-2 division
  always_comb begin
    crc_t r;
    r = rem_i ^ {byte_i, {CrcByteShift{1'b0}}};
    for (int b = 0; b < ByteWidth; b++) begin
      if ((r & CrcTopBit) != '0) begin
        r = {r[CrcWidth-2:0], 1'b0} ^ poly_i;
      end else begin
        r = {r[CrcWidth-2:0], 1'b0};
      end
    end
    rem_o = r;
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for the msb-first crc-32 word engine
// depends on crc32w_pkg and crc32_msb_first_word_engine; reads no files
module testbench;
  import crc32w_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CrcWidth-1:0]   cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [CrcWidth-1:0]   data_word_i;
  logic [CountWidth-1:0] byte_count_i;
  logic                  first_word_i;
  logic                  last_word_i;
  logic [CrcWidth-1:0]   prior_crc_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [CrcWidth-1:0]   crc_result_o;

  // prediction state, mirrors the engine
  crc_t model_poly;
  crc_t model_remainder;
  crc_t expected_crc_q[$];

  int unsigned fail_count;
  int unsigned words_sent;
  int unsigned burst_left;
  int unsigned gap_max;
  int unsigned stall_mode;
  int unsigned stall_span;
  int unsigned stall_cycle;

  crc32_msb_first_word_engine u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .first_word_i (first_word_i),
    .last_word_i  (last_word_i),
    .prior_crc_i  (prior_crc_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .crc_result_o (crc_result_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // one byte into the remainder, msb first
  function automatic crc_t fold_byte(crc_t rem, byte_t data, crc_t poly);
    rem = rem ^ {data, {(CrcWidth-ByteWidth){1'b0}}};
    for (int b = 0; b < ByteWidth; b++) begin
      if ((rem & CrcTopBit) != '0) begin
        rem = (rem << 1) ^ poly;
      end else begin
        rem = rem << 1;
      end
    end
    return rem;
  endfunction

  // advance the remainder by one accepted item, queue the finished crc
  task automatic predict_word_crc(crc_t word, logic [CountWidth-1:0] count,
                                  logic first, logic last, crc_t prior);
    int unsigned nbytes;
    crc_t        rem;
    nbytes = 32'((count > ByteCountMax) ? ByteCountMax : count);
    rem = first ? (prior ^ CrcAllOnes) : model_remainder;
    for (int k = 0; k < nbytes; k++) begin
      rem = fold_byte(rem, word[CrcWidth-1-ByteWidth*k -: ByteWidth], model_poly);
    end
    model_remainder = rem;
    if (last) begin
      expected_crc_q.push_back(rem ^ CrcAllOnes);
    end
  endtask

  // send one item, with bursts and random gaps on the input side
  task automatic send_word(crc_t word, logic [CountWidth-1:0] count,
                           logic first, logic last, crc_t prior);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    data_word_i  <= word;
    byte_count_i <= count;
    first_word_i <= first;
    last_word_i  <= last;
    prior_crc_i  <= prior;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    predict_word_crc(word, count, first, last, prior);
  endtask

  // drop valid and wait until every result is in and the engine is quiet
  task automatic drain_engine();
    in_valid_i <= 1'b0;
    while (expected_crc_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // polynomial write, only while idle
  task automatic write_poly(crc_t poly);
    drain_engine();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= poly;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    model_poly = poly;
  endtask

  // well-formed message of n words with random content
  task automatic send_message(int unsigned n_words, bit fresh);
    logic [CountWidth-1:0] count;
    crc_t                  prior;
    prior = fresh ? '0 : crc_t'($urandom());
    for (int unsigned i = 0; i < n_words; i++) begin
      if (i == n_words - 1) begin
        count = CountWidth'($urandom_range(0, 7));
      end else if ($urandom_range(0, 9) > 7) begin
        count = CountWidth'($urandom_range(0, 7));
      end else begin
        count = ByteCountMax;
      end
      send_word($urandom(), count, i == 0, i == n_words - 1, prior);
    end
  endtask

  // word with no first flag right after reset continues from zero
  task automatic test_after_reset();
    send_word($urandom(), ByteCountMax, 1'b0, 1'b1, $urandom());
  endtask

  // standard check string, last word carries junk below its one byte
  task automatic test_check_string();
    send_word(32'h3132_3334, 3'd4, 1'b1, 1'b0, '0);
    send_word(32'h3536_3738, 3'd4, 1'b0, 1'b0, '0);
    send_word(32'h39AB_CDEF, 3'd1, 1'b0, 1'b1, '0);
  endtask

  // every byte count including the saturating ones
  task automatic test_byte_counts();
    for (int c = 0; c < 8; c++) begin
      send_word((c % 2) ? CrcAllOnes : '0, CountWidth'(c), 1'b1, 1'b1, $urandom());
    end
  endtask

  // empty first-and-last words hand back the prior crc
  task automatic test_empty_words();
    send_word($urandom(), 3'd0, 1'b1, 1'b1, 32'hDEAD_BEEF);
    send_word($urandom(), 3'd0, 1'b1, 1'b1, '0);
    send_word($urandom(), 3'd0, 1'b1, 1'b1, CrcAllOnes);
  endtask

  // field extremes, and words that continue past a last word
  task automatic test_extremes();
    send_word('0, 3'd4, 1'b1, 1'b0, CrcAllOnes);
    send_word(CrcAllOnes, 3'd4, 1'b0, 1'b1, '0);
    send_word(CrcAllOnes, 3'd4, 1'b0, 1'b1, CrcAllOnes);
    send_word($urandom(), 3'd2, 1'b0, 1'b0, $urandom());
    send_word($urandom(), 3'd3, 1'b0, 1'b1, $urandom());
    send_word('0, 3'd4, 1'b1, 1'b1, '0);
  endtask

  // extreme and odd polynomials, short messages under each
  task automatic test_polynomials();
    crc_t polys[5];
    polys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
              32'h1EDC_6F41};
    gap_max = 2;
    foreach (polys[p]) begin
      write_poly(polys[p]);
      repeat (12) send_message($urandom_range(1, 4), 1'($urandom_range(0, 1)));
    end
  endtask

  // mostly well-formed messages, some noise items with random flags
  task automatic test_random_traffic(int unsigned n_items);
    int unsigned phase_end;
    int unsigned gaps[4];
    gaps = '{0, 3, 8, 1};
    for (int ph = 0; ph < 4; ph++) begin
      write_poly((ph == 3) ? CrcPolyReset : crc_t'($urandom()));
      gap_max = gaps[ph];
      phase_end = words_sent + n_items / 4;
      while (words_sent < phase_end) begin
        if ($urandom_range(0, 99) < 85) begin
          send_message($urandom_range(1, 6), $urandom_range(0, 3) == 0);
        end else begin
          send_word($urandom(), CountWidth'($urandom_range(0, 7)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
        end
      end
    end
  endtask

  // receiver stall pattern, switches style after a random span
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(32, 256);
    end else begin
      stall_span--;
    end
    stall_cycle++;
    case (stall_mode)
      0: begin
        out_stall_i <= 1'b0;
      end
      1: begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        out_stall_i <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_stall_i <= ((stall_cycle % 5) < 2);
      end
    endcase
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_crc_q.size() == 0) begin
        $error("unexpected item: crc_result actual %h", crc_result_o);
        fail_count++;
      end else begin
        if (crc_result_o !== expected_crc_q[0]) begin
          $error("crc_result mismatch: expected %h, actual %h",
                 expected_crc_q[0], crc_result_o);
          fail_count++;
        end
        void'(expected_crc_q.pop_front());
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $error("timeout with %0d items outstanding", expected_crc_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // test sequence
  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    data_word_i  = '0;
    byte_count_i = '0;
    first_word_i = 1'b0;
    last_word_i  = 1'b0;
    prior_crc_i  = '0;
    out_stall_i  = 1'b0;
    fail_count   = 0;
    words_sent   = 0;
    burst_left   = 0;
    gap_max      = 0;
    stall_mode   = 0;
    stall_span   = 0;
    stall_cycle  = 0;
    model_poly      = CrcPolyReset;
    model_remainder = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_after_reset();
    test_check_string();
    test_byte_counts();
    test_empty_words();
    test_extremes();
    test_polynomials();
    test_random_traffic(1400);

    drain_engine();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/crc32w_pkg.sv
rtl/crc32w_fold.sv
rtl/crc32_msb_first_word_engine.sv
verif/testbench.sv
